FILE: sv/arpc_pkg.sv
// Shared constants and types for the ARP cache block.
`timescale 1ns / 1ps
package arpc_pkg;
    localparam int CACHE_ENTRIES   = 64;
    localparam int PENDING_ENTRIES = 16;
    localparam int CACHE_AW        = $clog2(CACHE_ENTRIES);
    localparam int PEND_AW         = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
    localparam int MAX_RESULTS     = 16;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_QUEUE  = 2'd2;
    localparam logic [1:0] OP_TICK   = 2'd3;

    localparam logic [2:0] RC_HIT        = 3'd0;
    localparam logic [2:0] RC_MISS       = 3'd1;
    localparam logic [2:0] RC_STORED     = 3'd2;
    localparam logic [2:0] RC_CACHE_FULL = 3'd3;
    localparam logic [2:0] RC_QUEUED     = 3'd4;
    localparam logic [2:0] RC_QUEUE_FULL = 3'd5;
    localparam logic [2:0] RC_SEND       = 3'd6;
    localparam logic [2:0] RC_GIVE_UP    = 3'd7;

    localparam logic [1:0] CFG_LIFETIME = 2'd0;
    localparam logic [1:0] CFG_RETRY    = 2'd1;
    localparam logic [1:0] CFG_LIMIT    = 2'd2;

    // Cache row: ip, mac, stamp.
    localparam int MAP_W  = 32 + 48 + 32;
    // Pending row: ip, stamp, sends.
    localparam int WAIT_W = 32 + 32 + 3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] ip_address;
        logic [47:0] mac_address;
    } req_t;

    typedef struct packed {
        logic [2:0]  result_code;
        logic [31:0] result_ip;
        logic [47:0] result_mac;
        logic        pending_flag;
        logic        last;
    } rsp_t;
endpackage

FILE: sv/arpc_if.sv
// Valid/ready channel interfaces for requests, results and configuration.
`timescale 1ns / 1ps
interface arpc_req_if;
    logic              valid;
    logic              ready;
    arpc_pkg::req_t    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface arpc_rsp_if;
    logic              valid;
    logic              ready;
    arpc_pkg::rsp_t    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface arpc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

FILE: sv/arpc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: sv/arpc_ctrl.sv
// Sequencer that walks the cache and pending tables for each request.
`timescale 1ns / 1ps
module arpc_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    arpc_req_if.sink                      req,
    arpc_rsp_if.source                    rsp,
    arpc_cfg_if.sink                      cfg,
    output logic                          tick_end,
    output logic                          map_we,
    output logic [arpc_pkg::CACHE_AW-1:0] map_waddr,
    output logic [arpc_pkg::MAP_W-1:0]    map_wdata,
    output logic [arpc_pkg::CACHE_AW-1:0] map_raddr,
    input  logic [arpc_pkg::MAP_W-1:0]    map_rdata,
    output logic                          wait_we,
    output logic [arpc_pkg::PEND_AW-1:0]  wait_waddr,
    output logic [arpc_pkg::WAIT_W-1:0]   wait_wdata,
    output logic [arpc_pkg::PEND_AW-1:0]  wait_raddr,
    input  logic [arpc_pkg::WAIT_W-1:0]   wait_rdata
);
    import arpc_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAP  = 3'd1;
    localparam logic [2:0] ST_WAIT = 3'd2;
    localparam logic [2:0] ST_DONE = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    localparam int CCW = CACHE_AW + 1;
    localparam int PCW = PEND_AW + 1;

    logic [2:0]  state_reg, state_next;
    req_t        cur_reg;
    logic [15:0] lifetime_reg;
    logic [7:0]  retry_reg;
    logic [2:0]  limit_reg;
    logic [31:0] now_reg;

    logic [CACHE_ENTRIES-1:0]   map_valid_reg;
    logic [PENDING_ENTRIES-1:0] wait_valid_reg;

    // Address counters; a read issued at one index returns data the next cycle.
    logic [CCW-1:0] mcnt_reg;
    logic [PCW-1:0] pcnt_reg;
    logic           rd_vld_reg;
    logic [CACHE_AW-1:0] ridx_m_reg;
    logic [PEND_AW-1:0]  ridx_p_reg;

    // Search outcomes.
    logic                hit_reg;
    logic [47:0]         hit_mac_reg;
    logic                pend_found_reg;
    logic [PEND_AW-1:0]  pend_idx_reg;
    logic [5:0]          nres_reg;

    rsp_t out_reg;
    logic out_vld_reg;

    logic [31:0] m_ip, m_stamp, w_ip, w_stamp;
    logic [47:0] m_mac;
    logic [2:0]  w_sends;
    assign {m_ip, m_mac, m_stamp}     = map_rdata;
    assign {w_ip, w_stamp, w_sends}   = wait_rdata;

    logic cache_free, wait_free;
    logic [CACHE_AW-1:0] cache_free_idx;
    logic [PEND_AW-1:0]  wait_free_idx;

    always_comb
    begin
        cache_free = 1'b0;
        cache_free_idx = '0;
        for (int i = CACHE_ENTRIES - 1; i >= 0; i--)
        begin
            if (!map_valid_reg[i])
            begin
                cache_free = 1'b1;
                cache_free_idx = CACHE_AW'(i);
            end
        end
        wait_free = 1'b0;
        wait_free_idx = '0;
        for (int j = PENDING_ENTRIES - 1; j >= 0; j--)
        begin
            if (!wait_valid_reg[j])
            begin
                wait_free = 1'b1;
                wait_free_idx = PEND_AW'(j);
            end
        end
    end

    logic rsp_free;
    assign rsp_free = !out_vld_reg || rsp.ready;

    assign req.ready = (state_reg == ST_IDLE) && !out_vld_reg;
    assign cfg.ready = 1'b1;
    assign rsp.valid = out_vld_reg;
    assign rsp.data  = out_reg;

    logic m_age_out, w_due;
    assign m_age_out = (now_reg - m_stamp) > {16'd0, lifetime_reg};
    assign w_due     = (w_sends == 3'd0) || ((now_reg - w_stamp) > {24'd0, retry_reg});

    logic w_emit;
    assign w_emit = (state_reg == ST_WAIT) && (cur_reg.operation == OP_TICK) && rd_vld_reg &&
                    wait_valid_reg[ridx_p_reg] && w_due && (nres_reg < 6'(MAX_RESULTS));

    // Tick results are held one beat downstream so the final one can carry last.
    assign tick_end = (state_reg == ST_DONE) && (cur_reg.operation == OP_TICK) &&
                      (nres_reg != 6'd0) && rsp_free;

    logic m_scan_done, p_scan_done;
    assign m_scan_done = mcnt_reg == CCW'(CACHE_ENTRIES);
    assign p_scan_done = pcnt_reg == PCW'(PENDING_ENTRIES);

    assign map_raddr  = mcnt_reg[CACHE_AW-1:0];
    // A stalled beat keeps its entry on the read port until it can go out.
    assign wait_raddr = (w_emit && !rsp_free) ? ridx_p_reg : pcnt_reg[PEND_AW-1:0];

    always_comb
    begin
        map_we = 1'b0;
        map_waddr = cache_free_idx;
        map_wdata = {cur_reg.ip_address, cur_reg.mac_address, now_reg};
        wait_we = 1'b0;
        wait_waddr = wait_free_idx;
        wait_wdata = {cur_reg.ip_address, 32'd0, 3'd0};
        if (state_reg == ST_WAIT && rd_vld_reg && cur_reg.operation == OP_TICK &&
            wait_valid_reg[ridx_p_reg] && w_due && w_sends < limit_reg &&
            nres_reg < 6'(MAX_RESULTS) && rsp_free)
        begin
            wait_we = 1'b1;
            wait_waddr = ridx_p_reg;
            wait_wdata = {w_ip, now_reg, w_sends + 3'd1};
        end
        else if (state_reg == ST_DONE && cur_reg.operation == OP_QUEUE &&
                 !pend_found_reg && wait_free && rsp_free)
        begin
            wait_we = 1'b1;
        end
        if (state_reg == ST_DONE && cur_reg.operation == OP_INSERT && cache_free && rsp_free)
        begin
            map_we = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (req.valid && req.ready)
                         state_next = (req.data.operation == OP_QUEUE ||
                                       req.data.operation == OP_INSERT) ? ST_WAIT : ST_MAP;
            ST_MAP:  if (m_scan_done && !rd_vld_reg)
                         state_next = (cur_reg.operation == OP_TICK) ? ST_WAIT : ST_DONE;
            ST_WAIT: if (p_scan_done && !rd_vld_reg)
                         state_next = ST_DONE;
            ST_DONE: if (rsp_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            lifetime_reg   <= 16'd15;
            retry_reg      <= 8'd1;
            limit_reg      <= 3'd5;
            now_reg        <= '0;
            map_valid_reg  <= '0;
            wait_valid_reg <= '0;
            mcnt_reg       <= '0;
            pcnt_reg       <= '0;
            rd_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            pend_found_reg <= 1'b0;
            nres_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_LIFETIME: lifetime_reg <= cfg.wdata;
                    CFG_RETRY:    retry_reg    <= cfg.wdata[7:0];
                    CFG_LIMIT:    limit_reg    <= cfg.wdata[2:0];
                    default:      ;
                endcase
            end
            if (out_vld_reg && rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid && req.ready)
                    begin
                        cur_reg <= req.data;
                        mcnt_reg <= '0;
                        pcnt_reg <= '0;
                        rd_vld_reg <= 1'b0;
                        hit_reg <= 1'b0;
                        pend_found_reg <= 1'b0;
                        nres_reg <= '0;
                        if (req.data.operation == OP_TICK)
                        begin
                            now_reg <= now_reg + 32'd1;
                        end
                    end
                end
                ST_MAP:
                begin
                    if (rd_vld_reg && map_valid_reg[ridx_m_reg])
                    begin
                        if (cur_reg.operation == OP_TICK)
                        begin
                            if (m_age_out)
                                map_valid_reg[ridx_m_reg] <= 1'b0;
                        end
                        else if (m_ip == cur_reg.ip_address)
                        begin
                            hit_reg <= 1'b1;
                            hit_mac_reg <= m_mac;
                        end
                    end
                    rd_vld_reg <= !m_scan_done;
                    ridx_m_reg <= mcnt_reg[CACHE_AW-1:0];
                    if (!m_scan_done)
                        mcnt_reg <= mcnt_reg + CCW'(1);
                end
                ST_WAIT:
                begin
                    // Ticks stall here while a result waits so no result is dropped.
                    if (w_emit)
                    begin
                        if (rsp_free)
                        begin
                            out_vld_reg <= 1'b1;
                            out_reg.result_code <= (w_sends >= limit_reg) ? RC_GIVE_UP : RC_SEND;
                            out_reg.result_ip <= w_ip;
                            out_reg.result_mac <= '0;
                            out_reg.pending_flag <= 1'b0;
                            out_reg.last <= 1'b0;
                            nres_reg <= nres_reg + 6'd1;
                            if (w_sends >= limit_reg)
                                wait_valid_reg[ridx_p_reg] <= 1'b0;
                            rd_vld_reg <= !p_scan_done;
                            ridx_p_reg <= pcnt_reg[PEND_AW-1:0];
                            if (!p_scan_done)
                                pcnt_reg <= pcnt_reg + PCW'(1);
                        end
                    end
                    else
                    begin
                        if (cur_reg.operation != OP_TICK && rd_vld_reg &&
                            wait_valid_reg[ridx_p_reg] && !pend_found_reg &&
                            w_ip == cur_reg.ip_address)
                        begin
                            pend_found_reg <= 1'b1;
                            pend_idx_reg <= ridx_p_reg;
                        end
                        rd_vld_reg <= !p_scan_done;
                        ridx_p_reg <= pcnt_reg[PEND_AW-1:0];
                        if (!p_scan_done)
                            pcnt_reg <= pcnt_reg + PCW'(1);
                    end
                end
                ST_DONE:
                begin
                    if (rsp_free && cur_reg.operation != OP_TICK)
                    begin
                        out_reg.result_ip <= cur_reg.ip_address;
                        out_reg.result_mac <= '0;
                        out_reg.pending_flag <= 1'b0;
                        out_reg.last <= 1'b1;
                        out_vld_reg <= 1'b1;
                        case (cur_reg.operation)
                            OP_LOOKUP:
                            begin
                                out_reg.result_code <= hit_reg ? RC_HIT : RC_MISS;
                                out_reg.result_mac <= hit_reg ? hit_mac_reg : 48'd0;
                            end
                            OP_INSERT:
                            begin
                                out_reg.pending_flag <= pend_found_reg;
                                out_reg.result_code <= cache_free ? RC_STORED : RC_CACHE_FULL;
                                if (pend_found_reg)
                                    wait_valid_reg[pend_idx_reg] <= 1'b0;
                                if (cache_free)
                                    map_valid_reg[cache_free_idx] <= 1'b1;
                            end
                            OP_QUEUE:
                            begin
                                out_reg.pending_flag <= pend_found_reg;
                                if (pend_found_reg)
                                    out_reg.result_code <= RC_QUEUED;
                                else if (wait_free)
                                begin
                                    out_reg.result_code <= RC_QUEUED;
                                    wait_valid_reg[wait_free_idx] <= 1'b1;
                                end
                                else
                                    out_reg.result_code <= RC_QUEUE_FULL;
                            end
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

FILE: sv/arpc_tick_buf.sv
// One-beat hold stage that marks the final result of an item.
`timescale 1ns / 1ps
module arpc_tick_buf (
    input  logic              clk,
    input  logic              rst_n,
    arpc_rsp_if.sink          up,
    arpc_rsp_if.source        dn,
    input  logic              tick_end
);
    import arpc_pkg::*;

    rsp_t hold_reg;
    logic hold_vld_reg;
    logic done_reg;

    // A beat is released once a successor arrives, when it already carries last, or as last once its item has ended.
    logic push, pop;
    assign dn.valid = hold_vld_reg && (up.valid || done_reg || hold_reg.last);
    assign dn.data  = '{result_code:  hold_reg.result_code,
                        result_ip:    hold_reg.result_ip,
                        result_mac:   hold_reg.result_mac,
                        pending_flag: hold_reg.pending_flag,
                        last:         hold_reg.last || done_reg};
    assign pop  = dn.valid && dn.ready;
    assign up.ready = !hold_vld_reg || pop;
    assign push = up.valid && up.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                hold_reg <= up.data;
                hold_vld_reg <= 1'b1;
            end
            else if (pop)
            begin
                hold_vld_reg <= 1'b0;
            end
            if (tick_end)
            begin
                done_reg <= 1'b1;
            end
            else if (pop)
            begin
                done_reg <= 1'b0;
            end
        end
    end
endmodule

FILE: sv/arp_cache_with_request_retry_top.sv
// A lookup walks all 64 cache slots before its result is offered; insert and queue walk
// the 16 pending slots before they answer. A tick walks both tables; its results stream
// out during the pending sweep and the final beat is released after that sweep, delayed
// by each stalled beat. Items are handled one at a time; the next is accepted only once
// the controller is idle and holds no unsent result. Reset: valid bits and the tick
// counter clear and the configuration registers take their defaults at once; no
// clearing pass.
`timescale 1ns / 1ps
module arp_cache_with_request_retry_top (
    input logic         clk,
    input logic         rst_n,
    arpc_req_if.sink    req,
    arpc_rsp_if.source  rsp,
    arpc_cfg_if.sink    cfg
);
    import arpc_pkg::*;

    logic                map_we, wait_we;
    logic [CACHE_AW-1:0] map_waddr, map_raddr;
    logic [PEND_AW-1:0]  wait_waddr, wait_raddr;
    logic [MAP_W-1:0]    map_wdata, map_rdata;
    logic [WAIT_W-1:0]   wait_wdata, wait_rdata;
    logic                tick_end;

    arpc_rsp_if ctrl_rsp ();

    arpc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(ctrl_rsp), .cfg(cfg),
        .tick_end(tick_end),
        .map_we(map_we), .map_waddr(map_waddr), .map_wdata(map_wdata),
        .map_raddr(map_raddr), .map_rdata(map_rdata),
        .wait_we(wait_we), .wait_waddr(wait_waddr), .wait_wdata(wait_wdata),
        .wait_raddr(wait_raddr), .wait_rdata(wait_rdata)
    );

    arpc_tick_buf u_tick_buf (
        .clk(clk), .rst_n(rst_n), .up(ctrl_rsp), .dn(rsp), .tick_end(tick_end)
    );

    arpc_ram #(.WIDTH(MAP_W), .DEPTH(CACHE_ENTRIES)) u_map_ram (
        .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
        .raddr(map_raddr), .rdata(map_rdata)
    );

    arpc_ram #(.WIDTH(WAIT_W), .DEPTH(PENDING_ENTRIES)) u_wait_ram (
        .clk(clk), .we(wait_we), .waddr(wait_waddr), .wdata(wait_wdata),
        .raddr(wait_raddr), .rdata(wait_rdata)
    );
endmodule

FILE: tb/sv/arp_cache_with_request_retry_top_tb.sv
// Self-checking testbench for the ARP cache with pending request retry.
`timescale 1ns / 1ps
module arp_cache_with_request_retry_top_tb;
    import arpc_pkg::*;

    class arp_scoreboard;
        bit          map_valid [CACHE_ENTRIES];
        logic [31:0] map_ip [CACHE_ENTRIES];
        logic [47:0] map_mac [CACHE_ENTRIES];
        logic [31:0] map_stamp [CACHE_ENTRIES];
        bit          wait_valid [PENDING_ENTRIES];
        logic [31:0] wait_ip [PENDING_ENTRIES];
        logic [31:0] wait_stamp [PENDING_ENTRIES];
        logic [2:0]  wait_sends [PENDING_ENTRIES];
        logic [31:0] seconds_now;
        logic [15:0] lifetime;
        logic [7:0]  retry;
        logic [2:0]  limit;
        rsp_t        pending_results[$];
        int          mismatches;
        int          results_seen;

        function void clear();
            foreach (map_valid[i]) map_valid[i] = 0;
            foreach (wait_valid[i]) wait_valid[i] = 0;
            seconds_now = 0;
            lifetime = 15;
            retry = 1;
            limit = 5;
            mismatches = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                CFG_LIFETIME: lifetime = val;
                CFG_RETRY:    retry = val[7:0];
                CFG_LIMIT:    limit = val[2:0];
                default:      ;
            endcase
        endfunction

        function void push(logic [2:0] code, logic [31:0] ip, logic [47:0] mac,
                           logic flag);
            rsp_t r;
            r.result_code = code;
            r.result_ip = ip;
            r.result_mac = mac;
            r.pending_flag = flag;
            r.last = 0;
            pending_results.push_back(r);
        endfunction

        function void note_input(req_t q);
            int n;
            int hit;
            int slot;
            int found;
            int freeslot;
            bit removed;
            bit due;
            n = pending_results.size();
            case (q.operation)
                OP_LOOKUP:
                begin
                    hit = -1;
                    for (int i = 0; i < CACHE_ENTRIES; i++)
                        if (map_valid[i] && map_ip[i] == q.ip_address) hit = i;
                    if (hit >= 0) push(RC_HIT, q.ip_address, map_mac[hit], 0);
                    else push(RC_MISS, q.ip_address, 48'd0, 0);
                end
                OP_INSERT:
                begin
                    removed = 0;
                    slot = -1;
                    for (int i = 0; i < PENDING_ENTRIES; i++)
                        if (!removed && wait_valid[i] && wait_ip[i] == q.ip_address)
                        begin
                            wait_valid[i] = 0;
                            removed = 1;
                        end
                    for (int i = 0; i < CACHE_ENTRIES; i++)
                        if (slot < 0 && !map_valid[i]) slot = i;
                    if (slot >= 0)
                    begin
                        map_valid[slot] = 1;
                        map_ip[slot] = q.ip_address;
                        map_mac[slot] = q.mac_address;
                        map_stamp[slot] = seconds_now;
                        push(RC_STORED, q.ip_address, 48'd0, removed);
                    end
                    else push(RC_CACHE_FULL, q.ip_address, 48'd0, removed);
                end
                OP_QUEUE:
                begin
                    found = -1;
                    freeslot = -1;
                    for (int i = 0; i < PENDING_ENTRIES; i++)
                    begin
                        if (wait_valid[i] && wait_ip[i] == q.ip_address && found < 0)
                            found = i;
                        if (!wait_valid[i] && freeslot < 0) freeslot = i;
                    end
                    if (found >= 0) push(RC_QUEUED, q.ip_address, 48'd0, 1);
                    else if (freeslot >= 0)
                    begin
                        wait_valid[freeslot] = 1;
                        wait_ip[freeslot] = q.ip_address;
                        wait_stamp[freeslot] = 0;
                        wait_sends[freeslot] = 0;
                        push(RC_QUEUED, q.ip_address, 48'd0, 0);
                    end
                    else push(RC_QUEUE_FULL, q.ip_address, 48'd0, 0);
                end
                default:
                begin
                    seconds_now = seconds_now + 1;
                    for (int i = 0; i < CACHE_ENTRIES; i++)
                        if (map_valid[i] && (seconds_now - map_stamp[i]) > {16'd0, lifetime})
                            map_valid[i] = 0;
                    for (int i = 0; i < PENDING_ENTRIES; i++)
                    begin
                        if (pending_results.size() - n >= MAX_RESULTS || !wait_valid[i])
                            continue;
                        due = (wait_sends[i] == 0) ||
                              ((seconds_now - wait_stamp[i]) > {24'd0, retry});
                        if (!due) continue;
                        if (wait_sends[i] >= limit)
                        begin
                            wait_valid[i] = 0;
                            push(RC_GIVE_UP, wait_ip[i], 48'd0, 0);
                        end
                        else
                        begin
                            wait_stamp[i] = seconds_now;
                            wait_sends[i] = wait_sends[i] + 3'd1;
                            push(RC_SEND, wait_ip[i], 48'd0, 0);
                        end
                    end
                end
            endcase
            if (pending_results.size() > n)
                pending_results[pending_results.size() - 1].last = 1;
        endfunction

        function void check_result(rsp_t got);
            rsp_t exp;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result %h", got);
                return;
            end
            exp = pending_results.pop_front();
            if (got.result_code !== exp.result_code || got.result_ip !== exp.result_ip ||
                got.result_mac !== exp.result_mac ||
                got.pending_flag !== exp.pending_flag || got.last !== exp.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected code %0d ip %h mac %h flag %b last %b, got code %0d ip %h mac %h flag %b last %b",
                             exp.result_code, exp.result_ip, exp.result_mac,
                             exp.pending_flag, exp.last, got.result_code, got.result_ip,
                             got.result_mac, got.pending_flag, got.last);
            end
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 200000;

    logic clk;
    logic rst_n;
    arpc_req_if req ();
    arpc_rsp_if rsp ();
    arpc_cfg_if cfg ();

    arp_cache_with_request_retry_top uut (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
    );

    arp_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_off;
    int idle_cycles;
    int items_sent;
    logic [31:0] ip_pool [8];

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Result side: random back-pressure plus an optional long hold-off.
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready) sb.check_result(rsp.data);
        rsp.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
            (cfg.valid && cfg.ready) || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired with %0d results outstanding",
                     sb.pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // The valid line stays up between items unless the sender idles.
    task automatic send_item(logic [1:0] op, logic [31:0] ip, logic [47:0] mac);
        req_t q;
        q.operation = op;
        q.ip_address = ip;
        q.mac_address = mac;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 0;
            @(posedge clk);
        end
        req.valid <= 1;
        req.data <= q;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        sb.note_input(q);
        items_sent++;
    endtask

    task automatic drain();
        req.valid <= 0;
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
        cfg.valid <= 1;
        cfg.index <= idx;
        cfg.wdata <= val;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        sb.write_reg(idx, val);
        cfg.valid <= 0;
        @(posedge clk);
    endtask

    task automatic set_all(logic [15:0] life, logic [7:0] rt, logic [2:0] lim);
        drain();
        write_cfg(CFG_LIFETIME, life);
        write_cfg(CFG_RETRY, {8'd0, rt});
        write_cfg(CFG_LIMIT, {13'd0, lim});
    endtask

    // Mostly a small pool of addresses so lookups hit and queues collide.
    function automatic logic [31:0] pick_ip();
        if ($urandom_range(9) < 8) return ip_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    task automatic random_items(int count);
        int r;
        logic [1:0] op;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(99);
            op = (r < 30) ? OP_LOOKUP : (r < 55) ? OP_INSERT : (r < 80) ? OP_QUEUE : OP_TICK;
            send_item(op, pick_ip(), 48'({$urandom, $urandom}));
        end
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        rst_n = 0;
        req.valid = 0;
        req.data = '0;
        cfg.valid = 0;
        cfg.index = CFG_LIFETIME;
        cfg.wdata = '0;
        rsp.ready = 0;
        hold_off = 0;
        idle_cycles = 0;
        items_sent = 0;
        send_idle_pct = 22;
        recv_idle_pct = 70;
        ip_pool[0] = 32'h0000_0000;
        ip_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 8; i++) ip_pool[i] = $urandom;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes, miss, hit, duplicates, pending removal, retries.
        send_item(OP_LOOKUP, 32'h0, 48'h0);
        send_item(OP_INSERT, 32'h0, 48'hFFFF_FFFF_FFFF);
        send_item(OP_INSERT, 32'hFFFF_FFFF, 48'h0);
        send_item(OP_INSERT, 32'hFFFF_FFFF, 48'hAAAA_5555_AAAA);
        send_item(OP_LOOKUP, 32'hFFFF_FFFF, 48'h0);
        send_item(OP_LOOKUP, 32'h0, 48'hFFFF_FFFF_FFFF);
        send_item(OP_TICK, 32'h0, 48'h0);
        send_item(OP_QUEUE, 32'h1234_5678, 48'h0);
        send_item(OP_QUEUE, 32'h1234_5678, 48'h0);
        send_item(OP_QUEUE, 32'hFFFF_FFFE, 48'h0);
        for (int i = 0; i < 8; i++) send_item(OP_TICK, 32'h0, 48'h0);
        send_item(OP_QUEUE, 32'h0A00_0001, 48'h0);
        send_item(OP_INSERT, 32'h0A00_0001, 48'h5555_AAAA_5555);
        send_item(OP_LOOKUP, 32'h0A00_0001, 48'h0);

        // Fill both tables to reach the full results and a 16-result tick.
        set_all(16'hFFFF, 8'd0, 3'd0);
        for (int i = 0; i < 17; i++) send_item(OP_QUEUE, 32'hC0A8_0000 + i, 48'h0);
        for (int i = 0; i < 64; i++) send_item(OP_INSERT, $urandom, 48'({$urandom, $urandom}));
        send_item(OP_TICK, 32'h0, 48'h0);
        send_item(OP_TICK, 32'h0, 48'h0);

        // First idling pattern, with a long hold-off on the result side.
        set_all(16'd1, 8'd255, 3'd7);
        send_idle_pct = 22;
        recv_idle_pct = 70;
        fork
        begin
            hold_off = 1;
            repeat (1500) @(posedge clk);
            hold_off = 0;
        end
        random_items(105);
        join

        set_all(16'd4, 8'd2, 3'd3);
        send_idle_pct = 70;
        recv_idle_pct = 22;
        random_items(105);

        // No idling on either side; the sender drains all results after each batch of 50 items.
        set_all(16'd65535, 8'd1, 3'd1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_items(50);
        drain();
        random_items(50);
        drain();

        $display("Sent %0d items, checked %0d results over five register settings.",
                 items_sent, sb.results_seen);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
